FILE: src/ipu_pkg.sv
package ipu_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_SCALE  = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int SCALE_W  = 7;
  localparam int WIDTH_W  = 13;
  localparam int HEIGHT_W = 16;

  localparam logic [SCALE_W-1:0] SCALE_LIMIT = 7'd100;
  localparam int DEF_MAX_WIDTH = 4096;

  // result queue between front and output
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = QPW + 1;

  // one result beat
  typedef struct packed {
    logic       pixel_valid;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [1:0] pad;
    logic       row_end;
    logic       image_end;
    logic       rejected;
  } res_t;

  // zero bytes needed to bring 3*w*s bytes to a four-byte boundary
  function automatic logic [1:0] pad_calc(input logic [1:0] w_lo, input logic [1:0] s_lo);
    logic [3:0] prod;
    logic [5:0] bytes;
    prod  = {2'b00, w_lo} * {2'b00, s_lo};
    bytes = 6'(prod) * 6'd3;
    return 2'(2'd0 - bytes[1:0]);
  endfunction

endpackage

FILE: src/ipu_front.sv
module ipu_front
  import ipu_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_red,
  // toward the queue
  input  logic [QCW-1:0]        q_level,
  output logic                  s1_valid,
  output res_t                  s1_res
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LW = (AW + 1 > WIDTH_W) ? AW + 1 : WIDTH_W;

  logic [SCALE_W-1:0]  scale_factor;
  logic [WIDTH_W-1:0]  source_width;
  logic [HEIGHT_W-1:0] source_height;

  logic [AW-1:0]       load_column;
  logic                row_ready;
  logic [AW-1:0]       source_column;
  logic [SCALE_W-1:0]  horizontal_repeat;
  logic [SCALE_W-1:0]  vertical_repeat;
  logic [HEIGHT_W-1:0] rows_done;

  logic [23:0] line_store [MAX_WIDTH];
  logic [23:0] rdata;

  logic [SCALE_W-1:0]  s_eff;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  logic accept, is_load, reject, load_ok, pull_ok;
  logic last_load, last_rep, last_col, last_vrep, last_row, rend, iend;

  logic       s1_pull;
  logic [1:0] s1_pad;
  logic       s1_row_end, s1_image_end, s1_rejected;

  // configuration registers, always ready
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor  <= SCALE_W'(1);
      source_width  <= WIDTH_W'(1);
      source_height <= HEIGHT_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SCALE:  scale_factor  <= cfg_data[SCALE_W-1:0];
        CFG_WIDTH:  source_width  <= cfg_data[WIDTH_W-1:0];
        CFG_HEIGHT: source_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped limits
  always_comb begin
    if (scale_factor == '0) s_eff = SCALE_W'(1);
    else if (scale_factor > SCALE_LIMIT) s_eff = SCALE_LIMIT;
    else s_eff = scale_factor;

    if (source_width == '0) w_eff = WIDTH_W'(1);
    else if (32'(source_width) > MAX_WIDTH) w_eff = WIDTH_W'(MAX_WIDTH);
    else w_eff = source_width;

    h_eff = (source_height == '0) ? HEIGHT_W'(1) : source_height;
  end

  // room check counts the beat still in the read stage
  assign in_stall = (QCW'(q_level) + QCW'(s1_valid)) >= QCW'(QDEPTH);
  assign accept   = in_valid && !in_stall;

  // classify
  assign is_load = !op;
  assign reject  = is_load ? row_ready : !row_ready;
  assign load_ok = accept && is_load && !reject;
  assign pull_ok = accept && !is_load && !reject;

  // end-of-count tests
  assign last_load = (LW'(load_column) + LW'(1)) >= LW'(w_eff);
  assign last_rep  = ({1'b0, horizontal_repeat} + 8'd1) >= {1'b0, s_eff};
  assign last_col  = (LW'(source_column) + LW'(1)) >= LW'(w_eff);
  assign last_vrep = ({1'b0, vertical_repeat} + 8'd1) >= {1'b0, s_eff};
  assign last_row  = ({1'b0, rows_done} + 17'd1) >= {1'b0, h_eff};
  assign rend      = last_rep && last_col;
  assign iend      = rend && last_vrep && last_row;

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      load_column       <= '0;
      row_ready         <= 1'b0;
      source_column     <= '0;
      horizontal_repeat <= '0;
      vertical_repeat   <= '0;
      rows_done         <= '0;
    end else if (load_ok) begin
      if (last_load) begin
        load_column       <= '0;
        row_ready         <= 1'b1;
        source_column     <= '0;
        horizontal_repeat <= '0;
      end else begin
        load_column <= load_column + AW'(1);
      end
    end else if (pull_ok) begin
      if (!last_rep) begin
        horizontal_repeat <= horizontal_repeat + SCALE_W'(1);
      end else if (!last_col) begin
        horizontal_repeat <= '0;
        source_column     <= source_column + AW'(1);
      end else begin
        horizontal_repeat <= '0;
        source_column     <= '0;
        if (last_vrep) begin
          vertical_repeat <= '0;
          row_ready       <= 1'b0;
          rows_done       <= last_row ? '0 : rows_done + HEIGHT_W'(1);
        end else begin
          vertical_repeat <= vertical_repeat + SCALE_W'(1);
        end
      end
    end
  end

  // line store, at most one write or one read per beat
  always_ff @(posedge clk) begin
    if (load_ok) line_store[load_column] <= {in_red, in_green, in_blue};
    if (pull_ok) rdata <= line_store[source_column];
  end

  // read stage flags
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pull      <= pull_ok;
      s1_rejected  <= reject;
      s1_row_end   <= pull_ok && rend;
      s1_image_end <= pull_ok && iend;
      s1_pad       <= (pull_ok && rend) ? pad_calc(w_eff[1:0], s_eff[1:0]) : 2'd0;
    end
  end

  always_comb begin
    s1_res.pixel_valid = s1_pull;
    s1_res.blue        = s1_pull ? rdata[7:0]   : 8'd0;
    s1_res.green       = s1_pull ? rdata[15:8]  : 8'd0;
    s1_res.red         = s1_pull ? rdata[23:16] : 8'd0;
    s1_res.pad         = s1_pad;
    s1_res.row_end     = s1_row_end;
    s1_res.image_end   = s1_image_end;
    s1_res.rejected    = s1_rejected;
  end

endmodule

FILE: src/ipu_queue.sv
module ipu_queue
  import ipu_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  res_t           push_res,
  output logic [QCW-1:0] level,
  output logic           out_valid,
  input  logic           out_stall,
  output res_t           head
);

  res_t           q_mem [QDEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic           pop;

  assign out_valid = (level != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = q_mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPW'(1);
      if (pop)  rd_ptr <= rd_ptr + QPW'(1);
      level <= level + QCW'(push) - QCW'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= push_res;
  end

endmodule

FILE: src/integer_pixel_upscaler_top.sv
// Nearest-neighbor integer upscaler for 24-bit raster rows.
// Input channel (in_valid / in_stall): op 0 loads one source pixel into the
// line store, op 1 pulls the next output pixel once a full row is held.
// Every accepted beat gives exactly one result beat on the output channel
// (out_valid / out_stall): a pixel with row_end, image_end and pad_bytes,
// an all-zero beat for a load, or a beat with rejected set.
// Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data):
// index 0 scale_factor, 1 source_width, 2 source_height; cfg_ready is
// always high. Write only while no beat is in flight.
// Throughput: one beat per cycle while in_stall is low, set by the single
// line store port that each beat uses at most once (write for a load, read
// for a pull). An accepted beat passes the registered line store read and
// then the four-entry result queue before the receiver can take it.
// When the receiver stalls, results collect in the queue and in_stall
// rises once the queue and the read stage hold four beats.
// Reset clears counters, the row flag, the queue and the registers to
// their defaults; line store contents stay undefined until loaded, with
// no clearing pass.
module integer_pixel_upscaler_top
  import ipu_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_red,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  pixel_valid,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_green,
  output logic [7:0]            out_red,
  output logic [1:0]            pad_bytes,
  output logic                  row_end,
  output logic                  image_end,
  output logic                  rejected
);

  logic           s1_valid;
  res_t           s1_res;
  logic [QCW-1:0] q_level;
  res_t           head;

  assign cfg_ready = 1'b1;

  // front: classify, count, line store
  ipu_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .in_blue  (in_blue),
    .in_green (in_green),
    .in_red   (in_red),
    .q_level  (q_level),
    .s1_valid (s1_valid),
    .s1_res   (s1_res)
  );

  // back: result queue feeding the output
  ipu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (s1_valid),
    .push_res (s1_res),
    .level    (q_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head     (head)
  );

  assign pixel_valid = head.pixel_valid;
  assign out_blue    = head.blue;
  assign out_green   = head.green;
  assign out_red     = head.red;
  assign pad_bytes   = head.pad;
  assign row_end     = head.row_end;
  assign image_end   = head.image_end;
  assign rejected    = head.rejected;

endmodule

FILE: src/ipu_checker.sv
module ipu_checker
  import ipu_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  op,
  input logic [7:0]            in_blue,
  input logic [7:0]            in_green,
  input logic [7:0]            in_red,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  pixel_valid,
  input logic [7:0]            out_blue,
  input logic [7:0]            out_green,
  input logic [7:0]            out_red,
  input logic [1:0]            pad_bytes,
  input logic                  row_end,
  input logic                  image_end,
  input logic                  rejected
);

  // nothing to deliver right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat shown right after reset");

  // a rejected beat carries nothing else
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> !pixel_valid && !row_end && !image_end && pad_bytes == 2'd0
      && out_blue == 8'd0 && out_green == 8'd0 && out_red == 8'd0)
    else $error("rejected beat with payload");

  // image end and padding only on a pixel that ends a row
  a_row_marks: assert property (@(posedge clk) disable iff (rst)
    out_valid && (image_end || pad_bytes != 2'd0) |-> row_end && pixel_valid)
    else $error("image end or padding off a row end");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({pixel_valid, out_blue, out_green,
      out_red, pad_bytes, row_end, image_end, rejected}))
    else $error("stalled result changed");

endmodule

bind integer_pixel_upscaler_top ipu_checker u_ipu_checker (.*);
